// ----- hw/rtl/bppf_pkg.sv -----
// Shared constants, codes and controller/datapath handshake structs for
// the body polygon point filter. No dependencies.
package bppf_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_VERTICES_DEFAULT = 16;
   localparam int COORD_WIDTH_DEFAULT  = 24;

   // Fixed field widths
   localparam int INDEX_WIDTH     = 4;
   localparam int COUNT_WIDTH     = 5;
   localparam int INTENSITY_WIDTH = 16;
   localparam int CSR_INDEX_WIDTH = 2;

   // Smallest polygon that can enclose anything
   localparam int MIN_VERTICES = 3;

   // Reset values of the z limits
   localparam int BODY_Z_LOW_RESET  = -2048;
   localparam int BODY_Z_HIGH_RESET = 0;

   // Item commands
   localparam logic CMD_WRITE_VERTEX = 1'b0;
   localparam logic CMD_CLASSIFY     = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BODY_ENABLE  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_VERTEX_COUNT = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BODY_Z_LOW   = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_BODY_Z_HIGH  = 2'd3;

   // Controller to datapath
   typedef struct packed {
      logic accept_vertex;
      logic accept_point;
      logic issue;
      logic load_out;
   } ctrl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic point_active;
      logic last_issue;
      logic pipe_busy;
      logic in_body;
      logic out_free;
   } ctrl_status_type;

endpackage

// ----- hw/rtl/bppf_if.sv -----
// Item channel interfaces: request (vertex write / point) and result (kept point).
// Depends on bppf_pkg.
interface bppf_req_if
   import bppf_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic [INDEX_WIDTH-1:0]        vertex_index;
   logic signed [COORD_WIDTH-1:0] vertex_x;
   logic signed [COORD_WIDTH-1:0] vertex_y;
   logic signed [COORD_WIDTH-1:0] point_x;
   logic signed [COORD_WIDTH-1:0] point_y;
   logic signed [COORD_WIDTH-1:0] point_z;
   logic [INTENSITY_WIDTH-1:0]    intensity;

   modport source (output valid, command, vertex_index, vertex_x, vertex_y,
                   point_x, point_y, point_z, intensity, input ready);
   modport sink   (input valid, command, vertex_index, vertex_x, vertex_y,
                   point_x, point_y, point_z, intensity, output ready);
endinterface

interface bppf_rsp_if
   import bppf_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] out_x;
   logic signed [COORD_WIDTH-1:0] out_y;
   logic signed [COORD_WIDTH-1:0] out_z;
   logic [INTENSITY_WIDTH-1:0]    out_intensity;

   modport source (output valid, out_x, out_y, out_z, out_intensity, input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_intensity, output ready);
endinterface

// ----- hw/rtl/body_polygon_point_filter_unit.sv -----
// Vertex write: the controller stays idle, so the next item is taken in the following cycle.
// Point: n+1 reads (n = clamped vertex count, n >= 3) of the one-edge-per-cycle sweep pass
// through the read/difference/product/compare pipeline; a point outside the polygon is then
// loaded into the output register, and no next item is taken until the point is done. With
// removal off (or n < 3, or z outside the limits) the sweep is skipped and the point goes out.
// Input stalls while a result waits for the output register. Synchronous active-high reset
// clears control, valid flags and configuration; vertex memory and data are not cleared.
module body_polygon_point_filter_unit
   import bppf_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT,
   parameter int COORD_WIDTH  = COORD_WIDTH_DEFAULT
)(
   input  logic                       clock,
   input  logic                       reset,
   bppf_req_if.sink                   req_ch,
   bppf_rsp_if.source                 rsp_ch,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [COORD_WIDTH-1:0]     csr_write_data
);

   ctrl_cmd_type    cmd;
   ctrl_status_type stat;
   logic            req_ready;

   assign req_ch.ready = req_ready;

   bppf_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_command (req_ch.command),
      .req_ready   (req_ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   bppf_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .COORD_WIDTH  (COORD_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .vertex_index     (req_ch.vertex_index),
      .vertex_x         (req_ch.vertex_x),
      .vertex_y         (req_ch.vertex_y),
      .point_x          (req_ch.point_x),
      .point_y          (req_ch.point_y),
      .point_z          (req_ch.point_z),
      .intensity        (req_ch.intensity),
      .cmd              (cmd),
      .stat             (stat),
      .out_valid        (rsp_ch.valid),
      .out_ready        (rsp_ch.ready),
      .out_x            (rsp_ch.out_x),
      .out_y            (rsp_ch.out_y),
      .out_z            (rsp_ch.out_z),
      .out_intensity    (rsp_ch.out_intensity)
   );

endmodule

// ----- hw/rtl/bppf_controller.sv -----
// Sequencing state machine: accepts items, runs the edge sweep, drains the
// datapath pipeline and hands the result over. Depends on bppf_pkg.
module bppf_controller
   import bppf_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_command,
   output logic            req_ready,
   input  ctrl_status_type stat,
   output ctrl_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SWEEP = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_command == CMD_WRITE_VERTEX) begin
                  cmd.accept_vertex = 1'b1;
               end else begin
                  cmd.accept_point = 1'b1;
                  state_in = stat.point_active ? ST_SWEEP : ST_DONE;
               end
            end
         end
         ST_SWEEP: begin
            cmd.issue = 1'b1;
            if (stat.last_issue) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) state_in = ST_DONE;
         end
         ST_DONE: begin
            // inside the body: drop; otherwise wait for the output register
            if (stat.in_body) begin
               state_in = ST_IDLE;
            end else if (stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// ----- hw/rtl/bppf_datapath.sv -----
// Datapath: registers, vertex memory, edge pipeline (read, differences,
// products, compare) and the output register. Depends on bppf_pkg.
module bppf_datapath
   import bppf_pkg::*;
#(
   parameter int MAX_VERTICES = MAX_VERTICES_DEFAULT,
   parameter int COORD_WIDTH  = COORD_WIDTH_DEFAULT
)(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [COORD_WIDTH-1:0]        csr_write_data,
   input  logic [INDEX_WIDTH-1:0]        vertex_index,
   input  logic signed [COORD_WIDTH-1:0] vertex_x,
   input  logic signed [COORD_WIDTH-1:0] vertex_y,
   input  logic signed [COORD_WIDTH-1:0] point_x,
   input  logic signed [COORD_WIDTH-1:0] point_y,
   input  logic signed [COORD_WIDTH-1:0] point_z,
   input  logic [INTENSITY_WIDTH-1:0]    intensity,
   input  ctrl_cmd_type                  cmd,
   output ctrl_status_type               stat,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [COORD_WIDTH-1:0] out_x,
   output logic signed [COORD_WIDTH-1:0] out_y,
   output logic signed [COORD_WIDTH-1:0] out_z,
   output logic [INTENSITY_WIDTH-1:0]    out_intensity
);

   localparam int ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CNT_W  = $clog2(MAX_VERTICES + 1);
   localparam int CMP_W  = (CNT_W > COUNT_WIDTH) ? CNT_W : COUNT_WIDTH;
   localparam int DW     = COORD_WIDTH + 1;
   localparam int PW     = 2 * DW;

   // Configuration registers
   logic                          enable_ff;
   logic [COUNT_WIDTH-1:0]        count_ff;
   logic signed [COORD_WIDTH-1:0] z_low_ff, z_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         count_ff  <= '0;
         z_low_ff  <= COORD_WIDTH'(BODY_Z_LOW_RESET);
         z_high_ff <= COORD_WIDTH'(BODY_Z_HIGH_RESET);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_BODY_ENABLE:  enable_ff <= csr_write_data[0];
            CSR_VERTEX_COUNT: count_ff  <= csr_write_data[COUNT_WIDTH-1:0];
            CSR_BODY_Z_LOW:   z_low_ff  <= csr_write_data;
            CSR_BODY_Z_HIGH:  z_high_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Effective vertex count and the removal precondition
   logic [CMP_W-1:0] count_ext;
   logic [CNT_W-1:0] n_eff;
   assign count_ext = CMP_W'(count_ff);
   assign n_eff     = (count_ext > CMP_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES)
                                                         : CNT_W'(count_ext);
   assign stat.point_active = enable_ff && (n_eff >= CNT_W'(MIN_VERTICES))
                              && (point_z >= z_low_ff) && (point_z <= z_high_ff);

   // Latched point and sweep counter
   logic signed [COORD_WIDTH-1:0] px_ff, py_ff, pz_ff;
   logic [INTENSITY_WIDTH-1:0]    int_ff;
   logic [CNT_W-1:0]              n_ff, step_ff;
   logic [CNT_W-1:0]              n_m1, step_m1;
   logic [ADDR_W-1:0]             rd_addr;

   always_ff @(posedge clock) begin
      if (cmd.accept_point) begin
         px_ff  <= point_x;
         py_ff  <= point_y;
         pz_ff  <= point_z;
         int_ff <= intensity;
         n_ff   <= n_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)                 step_ff <= '0;
      else if (cmd.accept_point) step_ff <= '0;
      else if (cmd.issue)        step_ff <= step_ff + 1'b1;
   end

   // first read fetches the closing vertex n-1, then 0 .. n-1
   assign n_m1            = n_ff - 1'b1;
   assign step_m1         = step_ff - 1'b1;
   assign rd_addr         = (step_ff == '0) ? n_m1[ADDR_W-1:0] : step_m1[ADDR_W-1:0];
   assign stat.last_issue = (step_ff == n_ff);

   // Vertex memory: one write port, one registered read port
   logic signed [COORD_WIDTH-1:0] mem_x [MAX_VERTICES];
   logic signed [COORD_WIDTH-1:0] mem_y [MAX_VERTICES];
   logic signed [COORD_WIDTH-1:0] rd_x_ff, rd_y_ff;
   logic [ADDR_W-1:0]             wr_addr;
   logic                          wr_ok;

   assign wr_addr = ADDR_W'(vertex_index);
   assign wr_ok   = (32'(vertex_index) < MAX_VERTICES);

   always_ff @(posedge clock) begin
      if (cmd.accept_vertex && wr_ok) begin
         mem_x[wr_addr] <= vertex_x;
         mem_y[wr_addr] <= vertex_y;
      end
      if (cmd.issue) begin
         rd_x_ff <= mem_x[rd_addr];
         rd_y_ff <= mem_y[rd_addr];
      end
   end

   // Pipeline valid flags
   logic rd_valid_ff, rd_first_ff, edge_valid_ff, prod_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         rd_first_ff   <= 1'b0;
         edge_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff   <= cmd.issue;
         rd_first_ff   <= (step_ff == '0);
         edge_valid_ff <= rd_valid_ff && !rd_first_ff;
         prod_valid_ff <= edge_valid_ff;
      end
   end

   assign stat.pipe_busy = rd_valid_ff || edge_valid_ff || prod_valid_ff;

   // Edge stage: vertex i is the fresh read, vertex j the previous one
   logic signed [COORD_WIDTH-1:0] prev_x_ff, prev_y_ff;
   logic signed [DW-1:0]          d_pxi_ff, d_dy_ff, d_xji_ff, d_pyi_ff;
   logic                          straddle_ff, dy_pos_ff;

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         prev_x_ff   <= rd_x_ff;
         prev_y_ff   <= rd_y_ff;
         d_pxi_ff    <= DW'(px_ff) - DW'(rd_x_ff);
         d_dy_ff     <= DW'(prev_y_ff) - DW'(rd_y_ff);
         d_xji_ff    <= DW'(prev_x_ff) - DW'(rd_x_ff);
         d_pyi_ff    <= DW'(py_ff) - DW'(rd_y_ff);
         straddle_ff <= (rd_y_ff > py_ff) != (prev_y_ff > py_ff);
         dy_pos_ff   <= (prev_y_ff > rd_y_ff);
      end
   end

   // Product stage: (px-xi)*dy against (xj-xi)*(py-yi)
   logic signed [PW-1:0] prod_a_ff, prod_b_ff;
   logic                 straddle_p_ff, dy_pos_p_ff;

   always_ff @(posedge clock) begin
      if (edge_valid_ff) begin
         prod_a_ff     <= d_pxi_ff * d_dy_ff;
         prod_b_ff     <= d_xji_ff * d_pyi_ff;
         straddle_p_ff <= straddle_ff;
         dy_pos_p_ff   <= dy_pos_ff;
      end
   end

   // Compare stage: toggle parity on each crossing
   logic crossing;
   logic inside_ff;
   assign crossing = dy_pos_p_ff ? (prod_a_ff < prod_b_ff) : (prod_b_ff < prod_a_ff);

   always_ff @(posedge clock) begin
      if (reset)                 inside_ff <= 1'b0;
      else if (cmd.accept_point) inside_ff <= 1'b0;
      else if (prod_valid_ff && straddle_p_ff && crossing) inside_ff <= ~inside_ff;
   end

   assign stat.in_body = inside_ff;

   // Output register
   logic out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset)             out_valid_ff <= 1'b0;
      else if (cmd.load_out) out_valid_ff <= 1'b1;
      else if (out_ready)    out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_x         <= px_ff;
         out_y         <= py_ff;
         out_z         <= pz_ff;
         out_intensity <= int_ff;
      end
   end

   assign out_valid     = out_valid_ff;
   assign stat.out_free = !out_valid_ff || out_ready;

endmodule

// ----- hw/rtl/bppf_checker.sv -----
// Port-level checks for the body polygon point filter, bound to the top level.
// Depends on bppf_pkg and body_polygon_point_filter_unit.
module bppf_checker
   import bppf_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
)(
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_command,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [COORD_WIDTH-1:0] out_x
);

   // ready drops in the cycle after a point is taken
   a_point_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == CMD_CLASSIFY |=> !req_ready)
      else $error("ready stayed high after a point was taken");

   // a vertex write never stalls the next item
   a_vertex_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == CMD_WRITE_VERTEX |=> req_ready)
      else $error("vertex write held the input channel");

   // a new result only appears while a point is being finished
   a_result_from_point: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a point in flight");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_x))
      else $error("stalled result changed or vanished");

   // reset empties the output
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind body_polygon_point_filter_unit bppf_checker #(.COORD_WIDTH(COORD_WIDTH)) u_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .req_command (req_ch.command),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .out_x       (rsp_ch.out_x)
);
